/* sv/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and helper functions for the fuzzy subsequence
// scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

   localparam int CHAR_WIDTH      = 8;
   localparam int SCORE_WIDTH     = 8;
   localparam int QLEN_WIDTH      = 5;
   localparam int QUERY_BYTES     = 16;
   localparam int QIDX_WIDTH      = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_CHARS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_CHARS_HIGH = 2'd2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH      = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_BACKSLASH  = 8'h5C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DASH       = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CASE_OFFSET     = 8'h20;

   localparam logic [SCORE_WIDTH-1:0] BOUNDARY_BONUS = 8'd5;
   localparam logic [SCORE_WIDTH-1:0] EMPTY_SCORE    = 8'd1;
   localparam logic [SCORE_WIDTH-1:0] MAX_SCORE      = 8'd216;

   typedef struct packed {
      logic [QLEN_WIDTH-1:0]  position;
      logic [QLEN_WIDTH-1:0]  run;
      logic [SCORE_WIDTH-1:0] score;
      logic [CHAR_WIDTH-1:0]  prev_char;
      logic                   at_first;
   } match_state_type;

   localparam match_state_type MATCH_STATE_RESET = '{
      position:  '0,
      run:       '0,
      score:     '0,
      prev_char: '0,
      at_first:  1'b1
   };

   function automatic logic [CHAR_WIDTH-1:0] fold_lower(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

/* sv/fss_req_if.sv */
// ----------------------------------------------------------------------------
// fss_req_if
// Valid/ready channel carrying one target character per transfer.
// ----------------------------------------------------------------------------
interface fss_req_if;
   logic                             valid;
   logic                             ready;
   logic [fss_pkg::CHAR_WIDTH-1:0]   target_char;
   logic                             end_of_target;

   modport source (output valid, output target_char, output end_of_target, input ready);
   modport sink   (input valid, input target_char, input end_of_target, output ready);
endinterface

/* sv/fss_rsp_if.sv */
// ----------------------------------------------------------------------------
// fss_rsp_if
// Valid/ready channel carrying one score result per transfer.
// ----------------------------------------------------------------------------
interface fss_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fss_pkg::SCORE_WIDTH-1:0]  match_score;
   logic                             fully_matched;

   modport source (output valid, output match_score, output fully_matched, input ready);
   modport sink   (input valid, input match_score, input fully_matched, output ready);
endinterface

/* sv/fss_match_core.sv */
// ----------------------------------------------------------------------------
// fss_match_core
// Scores one target character against the query and gives the next
// matching state.
// ----------------------------------------------------------------------------
module fss_match_core (
   input  fss_pkg::match_state_type                        state_cur,
   input  logic [fss_pkg::CHAR_WIDTH-1:0]                  char_raw,
   input  logic [fss_pkg::QUERY_BYTES*fss_pkg::CHAR_WIDTH-1:0] query_chars,
   input  logic [fss_pkg::QLEN_WIDTH-1:0]                  len_in_use,
   output fss_pkg::match_state_type                        state_next
);

   logic [fss_pkg::CHAR_WIDTH-1:0] char_folded;
   logic [fss_pkg::CHAR_WIDTH-1:0] query_char;
   logic [fss_pkg::QIDX_WIDTH-1:0] query_idx;
   logic                           active;
   logic                           hit;
   logic                           boundary;
   logic [fss_pkg::SCORE_WIDTH-1:0] gain;

   always_comb begin
      char_folded = fss_pkg::fold_lower(char_raw);
      query_idx   = state_cur.position[fss_pkg::QIDX_WIDTH-1:0];
      query_char  = fss_pkg::fold_lower(query_chars[query_idx*fss_pkg::CHAR_WIDTH +:
                                                    fss_pkg::CHAR_WIDTH]);
      active      = state_cur.position < len_in_use;
      hit         = active && (char_folded == query_char);
      boundary    = state_cur.at_first ||
                    state_cur.prev_char == fss_pkg::CHAR_SLASH ||
                    state_cur.prev_char == fss_pkg::CHAR_BACKSLASH ||
                    state_cur.prev_char == fss_pkg::CHAR_DASH ||
                    state_cur.prev_char == fss_pkg::CHAR_UNDERSCORE;
      gain        = 8'd1 + 8'(state_cur.run) + (boundary ? fss_pkg::BOUNDARY_BONUS : 8'd0);

      state_next           = state_cur;
      state_next.prev_char = char_folded;
      state_next.at_first  = 1'b0;
      if (hit) begin
         state_next.score    = state_cur.score + gain;
         state_next.run      = state_cur.run + 5'd1;
         state_next.position = state_cur.position + 5'd1;
      end else if (active) begin
         state_next.run = '0;
      end
   end

endmodule

/* sv/fuzzy_subsequence_scorer.sv */
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Streams target path characters and scores them as a fuzzy subsequence
// match against a configured query of up to sixteen bytes.
// ----------------------------------------------------------------------------
// One character is taken per transfer and the block accepts a new character
// every clock cycle unless one is held back. Each character is registered in
// the input register; the scoring logic then updates the match state, and on
// the character marked as end of target the score goes to the result register.
// A character is held back only when it ends a target while an earlier result
// is still waiting in the result register. The query must be written through
// the csr port only while no target is in flight; the block does not enforce it.
module fuzzy_subsequence_scorer #(
   parameter int QUERY_MAX = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [fss_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fss_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   fss_req_if.sink                               req_chan,
   fss_rsp_if.source                             rsp_chan
);

   logic [fss_pkg::QLEN_WIDTH-1:0]                     query_length_ff;
   logic [fss_pkg::CSR_DATA_WIDTH-1:0]                 query_low_ff;
   logic [fss_pkg::CSR_DATA_WIDTH-1:0]                 query_high_ff;
   logic [fss_pkg::QLEN_WIDTH-1:0]                     len_in_use;

   logic                                               in_valid_ff;
   logic                                               in_valid_in;
   logic [fss_pkg::CHAR_WIDTH-1:0]                     in_char_ff;
   logic                                               in_last_ff;

   fss_pkg::match_state_type                           state_ff;
   fss_pkg::match_state_type                           state_in;
   fss_pkg::match_state_type                           state_step;

   logic                                               out_valid_ff;
   logic                                               out_valid_in;
   logic [fss_pkg::SCORE_WIDTH-1:0]                    out_score_ff;
   logic [fss_pkg::SCORE_WIDTH-1:0]                    out_score_in;
   logic                                               out_matched_ff;
   logic                                               out_matched_in;

   logic                                               advance;
   logic                                               req_transfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= '0;
         query_low_ff    <= '0;
         query_high_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            fss_pkg::CSR_QUERY_LENGTH: begin
               query_length_ff <= csr_write_data[fss_pkg::QLEN_WIDTH-1:0];
            end
            fss_pkg::CSR_QUERY_CHARS_LOW: begin
               query_low_ff <= csr_write_data;
            end
            fss_pkg::CSR_QUERY_CHARS_HIGH: begin
               query_high_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign len_in_use = (query_length_ff > fss_pkg::QLEN_WIDTH'(QUERY_MAX)) ?
                       fss_pkg::QLEN_WIDTH'(QUERY_MAX) : query_length_ff;

   fss_match_core u_core (
      .state_cur   (state_ff),
      .char_raw    (in_char_ff),
      .query_chars ({query_high_ff, query_low_ff}),
      .len_in_use  (len_in_use),
      .state_next  (state_step)
   );

   always_comb begin
      advance        = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
      req_chan.ready = !in_valid_ff || advance;
      req_transfer   = req_chan.valid && req_chan.ready;

      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? fss_pkg::MATCH_STATE_RESET : state_step;
      end

      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_score_in   = out_score_ff;
      out_matched_in = out_matched_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         if (len_in_use == '0) begin
            out_score_in   = fss_pkg::EMPTY_SCORE;
            out_matched_in = 1'b1;
         end else if (state_step.position >= len_in_use) begin
            out_score_in   = state_step.score;
            out_matched_in = 1'b1;
         end else begin
            out_score_in   = '0;
            out_matched_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= fss_pkg::MATCH_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_char_ff <= req_chan.target_char;
         in_last_ff <= req_chan.end_of_target;
      end
      out_score_ff   <= out_score_in;
      out_matched_ff <= out_matched_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.match_score   = out_score_ff;
   assign rsp_chan.fully_matched = out_matched_ff;

endmodule

/* sv/fss_checker.sv */
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks on the result channel of the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
module fss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [fss_pkg::SCORE_WIDTH-1:0]    rsp_match_score,
   input logic                               rsp_fully_matched
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_score) &&
                                  $stable(rsp_fully_matched))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fully_matched |-> rsp_match_score == '0)
      else $error("nonzero score without full match");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fully_matched |-> rsp_match_score != '0)
      else $error("zero score on full match");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_score <= fss_pkg::MAX_SCORE)
      else $error("score above reachable maximum");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_match_score   (rsp_chan.match_score),
   .rsp_fully_matched (rsp_chan.fully_matched)
);
